/* hdl/mcg_pkg.sv */
// Shared types, constants and small tables for the month calendar generator.
// Used by mcg_ctrl, mcg_datapath and month_calendar_generator.
`default_nettype none

package mcg_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WD_W    = 3;
    localparam int Y_W     = 15;   // year + 400 still fits
    localparam int Q_W     = 8;    // y / 100 of y up to year + 400
    localparam int Z_W     = 16;   // Zeller sum before mod 7

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_YEAR_SHIFT = 4'd12;

    localparam logic [Y_W-1:0] YEAR_OFFSET = 15'd400;

    // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x below 7989
    localparam logic [17:0] RECIP_25    = 18'd167773;
    localparam int          RECIP_SHIFT = 22;
    localparam int          PROD_W      = 31;

    localparam logic [Z_W-1:0] WEEK_BIAS = 16'd7000;

    localparam logic [WD_W-1:0] WD_SUNDAY   = 3'd0;
    localparam logic [WD_W-1:0] WD_SATURDAY = 3'd6;

    typedef struct packed {
        logic load;   // capture the input request
        logic div;    // form y / 100
        logic sum;    // form the Zeller sum and month length
        logic fold;   // reduce the sum mod 7
        logic emit;   // load the next day into the output register
    } mcg_cmd_t;

    typedef struct packed {
        logic out_free;  // output register empty or being taken
        logic day_last;  // current day is the last of the month
    } mcg_status_t;

    // floor(13 * (m + 1) / 5)
    function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        unique case (m)
            4'd0:    t = 6'd2;
            4'd1:    t = 6'd5;
            4'd2:    t = 6'd7;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd41;
        endcase
        return t;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:    d = leap ? 5'd29 : 5'd28;
            default: d = 5'd30;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* hdl/mcg_ctrl.sv */
// Sequencer for the month calendar generator: setup steps, then one day per cycle while the output is not stalled.
// Depends on mcg_pkg for the command and status structs.
`default_nettype none

module mcg_ctrl
    import mcg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire mcg_status_t status,
    output mcg_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_FOLD = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.load = in_ready && in_valid;
        cmd.div  = (state_reg == ST_DIV);
        cmd.sum  = (state_reg == ST_SUM);
        cmd.fold = (state_reg == ST_FOLD);
        cmd.emit = (state_reg == ST_EMIT) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_DIV;
            end
            ST_DIV:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_FOLD;
            ST_FOLD: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (cmd.emit && status.day_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* hdl/mcg_datapath.sv */
// Datapath for the month calendar generator: year arithmetic, Zeller sum,
// mod-7 fold, day counter and output register. Depends on mcg_pkg.
`default_nettype none

module mcg_datapath
    import mcg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mcg_cmd_t             cmd,
    output mcg_status_t               status,
    input  wire logic [YEAR_W-1:0]    in_year,
    input  wire logic [MONTH_W-1:0]   in_month,
    input  wire logic [MONTH_W-1:0]   in_today_month,
    input  wire logic [DAY_W-1:0]     in_today_day,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DAY_W-1:0]          out_day,
    output logic [WD_W-1:0]           out_weekday,
    output logic                      out_weekend,
    output logic                      out_today,
    output logic                      out_last
);

    logic [Y_W-1:0]     y_reg;
    logic [MONTH_W-1:0] mo_reg;
    logic [MONTH_W-1:0] tm_reg;
    logic [DAY_W-1:0]   td_reg;
    logic [Q_W-1:0]     q100_reg;
    logic [Z_W-1:0]     z_reg;
    logic [DAY_W-1:0]   days_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [WD_W-1:0]    wd_reg;

    logic               out_valid_reg;
    logic [DAY_W-1:0]   out_day_reg;
    logic [WD_W-1:0]    out_wd_reg;
    logic               out_weekend_reg;
    logic               out_today_reg;
    logic               out_last_reg;

    logic               in_jan_feb;
    logic [Y_W-1:0]     y_ext;
    logic [Y_W-1:0]     y_next;
    logic [PROD_W-1:0]  prod;
    logic               mo_jan_feb;
    logic [MONTH_W-1:0] zm;
    logic [Z_W-1:0]     z_next;
    logic [Y_W-1:0]     rem100_full;
    logic [6:0]         rem100;
    logic               leap;
    logic [5:0]         fold1;
    logic [3:0]         fold2;
    logic [WD_W-1:0]    zmod7;
    logic [WD_W-1:0]    wd0;
    logic [WD_W-1:0]    wd_inc;

    // January and February count as months 13 and 14 of the year before
    assign in_jan_feb = (in_month == MONTH_JAN) || (in_month == MONTH_FEB);
    assign y_ext      = {1'b0, in_year} + YEAR_OFFSET;
    assign y_next     = in_jan_feb ? (y_ext - 15'd1) : y_ext;

    // y / 100 = (y / 4) / 25
    assign prod = PROD_W'({5'd0, y_reg[Y_W-1:2]} * {13'd0, RECIP_25});

    assign mo_jan_feb = (mo_reg == MONTH_JAN) || (mo_reg == MONTH_FEB);
    assign zm         = mo_jan_feb ? (mo_reg + MONTH_YEAR_SHIFT) : mo_reg;

    assign z_next = Z_W'(1) + Z_W'(zeller_month_term(zm)) + Z_W'(y_reg)
                  + Z_W'(y_reg[Y_W-1:2]) + Z_W'(q100_reg[Q_W-1:2]) + WEEK_BIAS
                  - Z_W'(q100_reg);

    // For February y is year + 399: leap tests shift by one year
    assign rem100_full = y_reg - ({7'd0, q100_reg} * 15'd100);
    assign rem100      = rem100_full[6:0];
    assign leap = ((y_reg[1:0] == 2'd3) && (rem100 != 7'd99))
               || ((rem100 == 7'd99) && (q100_reg[1:0] == 2'd3));

    // mod 7 by summing octal digits, since 8 is 1 mod 7
    assign fold1 = 6'(z_reg[2:0]) + 6'(z_reg[5:3]) + 6'(z_reg[8:6])
                 + 6'(z_reg[11:9]) + 6'(z_reg[14:12]) + 6'(z_reg[15]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign zmod7 = (fold2 >= 4'd7) ? WD_W'(fold2 - 4'd7) : fold2[WD_W-1:0];
    // Zeller counts from Saturday; shift to Sunday
    assign wd0   = (zmod7 == 3'd0) ? WD_SATURDAY : (zmod7 - 3'd1);

    assign wd_inc = (wd_reg == WD_SATURDAY) ? WD_SUNDAY : (wd_reg + 3'd1);

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.day_last = (day_reg == days_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            y_reg  <= y_next;
            mo_reg <= in_month;
            tm_reg <= in_today_month;
            td_reg <= in_today_day;
        end
        if (cmd.div)
            q100_reg <= prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        if (cmd.sum)
        begin
            z_reg    <= z_next;
            days_reg <= month_days(mo_reg, leap);
        end
        if (cmd.fold)
        begin
            wd_reg  <= wd0;
            day_reg <= 5'd1;
        end
        else if (cmd.emit)
        begin
            wd_reg  <= wd_inc;
            day_reg <= day_reg + 5'd1;
        end
        if (cmd.emit)
        begin
            out_day_reg     <= day_reg;
            out_wd_reg      <= wd_reg;
            out_weekend_reg <= (wd_reg == WD_SUNDAY) || (wd_reg == WD_SATURDAY);
            out_today_reg   <= (mo_reg == tm_reg) && (day_reg == td_reg);
            out_last_reg    <= status.day_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid   = out_valid_reg;
    assign out_day     = out_day_reg;
    assign out_weekday = out_wd_reg;
    assign out_weekend = out_weekend_reg;
    assign out_today   = out_today_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire

/* hdl/month_calendar_generator.sv */
// Month calendar generator: one request in, one result per day of the month out.
// An accepted request steps through three setup steps, DIV, SUM and FOLD, then
// EMIT registers one day result per cycle while the output is not stalled; the
// next request is taken only after the last day of the month is emitted.
// Reset: rst_n asynchronous active low; clears sequencer state and output valid.
// Depends on mcg_pkg, mcg_ctrl and mcg_datapath.
`default_nettype none

module month_calendar_generator
    import mcg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [13:0] year, [17:14] month, [21:18] today_month, [26:22] today_day, rest zero
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] day_of_month, [7:5] weekday, [8] is_weekend, [9] is_today, rest zero
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    mcg_cmd_t         cmd;
    mcg_status_t      status;
    logic [DAY_W-1:0] out_day;
    logic [WD_W-1:0]  out_weekday;
    logic             out_weekend;
    logic             out_today;

    mcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mcg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_year        (s_axis_tdata[13:0]),
        .in_month       (s_axis_tdata[17:14]),
        .in_today_month (s_axis_tdata[21:18]),
        .in_today_day   (s_axis_tdata[26:22]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_day        (out_day),
        .out_weekday    (out_weekday),
        .out_weekend    (out_weekend),
        .out_today      (out_today),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_today, out_weekend, out_weekday, out_day};

`ifndef SYNTH
    // A month never ends before day 28
    a_last_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] >= 5'd28)
        else $error("month ended before day 28");

    a_weekend_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[8] ==
            ((m_axis_tdata[7:5] == WD_SUNDAY) || (m_axis_tdata[7:5] == WD_SATURDAY)))
        else $error("weekend flag disagrees with weekday");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:5] <= WD_SATURDAY)
        else $error("weekday out of range");

    // An accepted request holds off the next one while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");
`endif

endmodule

`default_nettype wire
